FILE: hdl/brb_pkg.sv
// Shared definitions for the byte ring buffer: action and status codes,
// field widths, stream payload layouts and default sizing.
// No dependencies.
`default_nettype none

package brb_pkg;

	// Default sizing
	localparam int unsigned DEPTH_DEF = 1024;
	localparam int unsigned GAP_DEF   = 8;

	// Field widths
	localparam int unsigned ACT_W    = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 10;
	localparam int unsigned STATUS_W = 2;

	// Stream widths, padded to whole bytes
	localparam int unsigned IN_W        = ACT_W + BYTE_W + CNT_W + CNT_W;
	localparam int unsigned OUT_W       = BYTE_W + STATUS_W + CNT_W + CNT_W;
	localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROP    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd2;

	// Request layout, last field in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]  offset;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] data_byte;
		logic [ACT_W-1:0]  action;
	} req_t;

	// Result layout, last field in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]    free_count;
		logic [CNT_W-1:0]    used_count;
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   read_byte;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/brb_mem.sv
// Byte store of the ring buffer: one write port, one read port with
// registered read data. Uses brb_pkg for the byte width.
`default_nettype none

module brb_mem #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [brb_pkg::BYTE_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [brb_pkg::BYTE_W-1:0] rd_data
);
	import brb_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/byte_ring_buffer.sv
// Byte ring buffer top level: pointer logic, request decode and result stages.
// Depends on brb_pkg and brb_mem.
// A result passes stage s1 and then the output register after its request is accepted.
// Throughput: one request per cycle unless m_tready stalls; one read/write pointer update per cycle.
// One further request is taken while a finished result waits on m_tready.
// Reset clears both pointers, the fill count and all valid flags; the byte store is not cleared.
`default_nettype none

module byte_ring_buffer #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
	parameter int unsigned GAP   = brb_pkg::GAP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// action[2:0], data_byte[10:3], count[20:11], offset[30:21], zero pad
	input  wire logic [brb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// result channel
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// read_byte[7:0], status[9:8], used_count[19:10], free_count[29:20], zero pad
	output logic      [brb_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import brb_pkg::*;

	localparam int unsigned PW  = $clog2(DEPTH);
	localparam int unsigned CW  = (PW > CNT_W) ? PW : CNT_W;
	localparam int unsigned SW  = CW + 1;
	localparam int unsigned CAP = DEPTH - GAP;

	// add modulo DEPTH; the sum is always below twice the depth
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [CW-1:0] inc);
		logic [SW-1:0] s;
		s = SW'(p) + SW'(inc);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	req_t req;
	logic accept;
	logic advance;

	logic [PW-1:0] rp_q, wp_q, used_q;
	logic [PW-1:0] rp_nx, wp_nx, used_nx, free_nx;
	logic [PW-1:0] free_w;
	logic [CW-1:0] used_x, free_x, count_x, offset_x, used_nx_x, free_nx_x;
	logic [PW-1:0] rd_addr;
	logic          wr_en, rd_en;
	logic [STATUS_W-1:0] st;

	logic                v_s1;
	logic [STATUS_W-1:0] st_s1;
	logic [CNT_W-1:0]    used_s1, free_s1;
	logic                rd_s1;
	logic [BYTE_W-1:0]   mem_rd;

	logic out_v_q;
	res_t out_q;

	assign req      = req_t'(s_tdata[IN_W-1:0]);
	assign advance  = !out_v_q || m_tready;
	assign s_tready = !v_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign free_w   = PW'(CAP) - used_q;
	assign used_x   = CW'(used_q);
	assign free_x   = CW'(free_w);
	assign count_x  = CW'(req.count);
	assign offset_x = CW'(req.offset);

	// request decode and pointer update
	always_comb begin
		st      = ST_DONE;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		rd_addr = rp_q;
		rp_nx   = rp_q;
		wp_nx   = wp_q;
		used_nx = used_q;
		unique case (req.action)
			ACT_PUSH: begin
				if (free_x == '0) begin
					st = ST_NO_SPACE;
				end else begin
					wr_en   = 1'b1;
					wp_nx   = wrap_add(wp_q, CW'(1));
					used_nx = used_q + PW'(1);
				end
			end
			ACT_POP: begin
				if (used_x == '0) begin
					st = ST_NO_DATA;
				end else begin
					rd_en   = 1'b1;
					rp_nx   = wrap_add(rp_q, CW'(1));
					used_nx = used_q - PW'(1);
				end
			end
			ACT_PEEK: begin
				if (offset_x >= used_x) begin
					st = ST_NO_DATA;
				end else begin
					rd_en   = 1'b1;
					rd_addr = wrap_add(rp_q, offset_x);
				end
			end
			ACT_DROP: begin
				if (count_x > used_x) begin
					st = ST_NO_DATA;
				end else begin
					rp_nx   = wrap_add(rp_q, count_x);
					used_nx = used_q - count_x[PW-1:0];
				end
			end
			ACT_ADVANCE: begin
				if (count_x > free_x) begin
					st = ST_NO_SPACE;
				end else begin
					wp_nx   = wrap_add(wp_q, count_x);
					used_nx = used_q + count_x[PW-1:0];
				end
			end
			ACT_CLEAR: begin
				rp_nx   = '0;
				wp_nx   = '0;
				used_nx = '0;
			end
			default: begin
			end
		endcase
	end

	assign free_nx   = PW'(CAP) - used_nx;
	assign used_nx_x = CW'(used_nx);
	assign free_nx_x = CW'(free_nx);

	// pointer and fill count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			used_q <= '0;
		end else if (accept) begin
			rp_q   <= rp_nx;
			wp_q   <= wp_nx;
			used_q <= used_nx;
		end
	end

	brb_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (accept && wr_en),
		.wr_addr(wp_q),
		.wr_data(req.data_byte),
		.rd_en  (accept && rd_en),
		.rd_addr(rd_addr),
		.rd_data(mem_rd)
	);

	// stage s1: status and counts, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1   <= st;
			used_s1 <= used_nx_x[CNT_W-1:0];
			free_s1 <= free_nx_x[CNT_W-1:0];
			rd_s1   <= rd_en;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			out_q.read_byte  <= rd_s1 ? mem_rd : '0;
			out_q.status     <= st_s1;
			out_q.used_count <= used_s1;
			out_q.free_count <= free_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule

`default_nettype wire

FILE: hdl/brb_checker.sv
// Port-level checks for the byte ring buffer, bound to its top level.
// Depends on brb_pkg and byte_ring_buffer.
`default_nettype none

module brb_checker #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
	parameter int unsigned GAP   = brb_pkg::GAP_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [brb_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import brb_pkg::*;

	localparam int unsigned CAP     = DEPTH - GAP;
	localparam bit          CAP_BIG = (CAP > ((1 << CNT_W) - 1));

	res_t res;
	assign res = res_t'(m_tdata[OUT_W-1:0]);

	// a result held back by the sink keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// used and free add up to the usable capacity whenever it fits the count fields
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAP_BIG ||
			((CNT_W + 1)'(res.used_count) + (CNT_W + 1)'(res.free_count) ==
			 (CNT_W + 1)'(CAP))))
		else $error("used plus free differs from capacity");

	// a refused request returns no byte, and the status code is defined
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res.status == ST_DONE) ||
			((res.status == ST_NO_SPACE || res.status == ST_NO_DATA) &&
			 res.read_byte == '0)))
		else $error("bad status or byte on refused request");

	// requests are only held off when a result is waiting on the sink
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("request channel stalled without output backpressure");

endmodule

bind byte_ring_buffer brb_checker #(
	.DEPTH(DEPTH),
	.GAP  (GAP)
) u_brb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

FILE: dv/brb_checker.sv
// Scoreboard for the byte ring buffer: watches the request and result streams,
// keeps its own ring store and pointers, and compares each result field by field.
// Depends on brb_pkg.
`default_nettype none

module brb_scoreboard #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
	parameter int unsigned GAP   = brb_pkg::GAP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [brb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [brb_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int unsigned                          fail_count,
	output int unsigned                          pending,
	output int unsigned                          req_total,
	output int unsigned                          res_total,
	output int unsigned                          refused_total
);
	import brb_pkg::*;

	localparam int unsigned CAP = DEPTH - GAP;

	// Ring contents and pointers as the block should hold them
	logic [BYTE_W-1:0] ring_mem [DEPTH];
	int unsigned       ring_rd;
	int unsigned       ring_wr;
	res_t              ring_answers [$];

	function automatic int unsigned ring_used();
		return (ring_wr + DEPTH - ring_rd) % DEPTH;
	endfunction

	function automatic int unsigned ring_free();
		int unsigned u;
		u = ring_used();
		return (u >= CAP) ? 0 : CAP - u;
	endfunction

	// Apply one request to the ring and return the result it should produce
	function automatic res_t ring_apply(req_t r);
		res_t        a;
		int unsigned u;
		int unsigned f;
		u = ring_used();
		f = ring_free();
		a = '0;
		a.status = ST_DONE;
		case (r.action)
			ACT_PUSH: begin
				if (f == 0) begin
					a.status = ST_NO_SPACE;
				end else begin
					ring_mem[ring_wr] = r.data_byte;
					ring_wr = (ring_wr + 1) % DEPTH;
				end
			end
			ACT_POP: begin
				if (u == 0) begin
					a.status = ST_NO_DATA;
				end else begin
					a.read_byte = ring_mem[ring_rd];
					ring_rd = (ring_rd + 1) % DEPTH;
				end
			end
			ACT_PEEK: begin
				if (r.offset >= u) begin
					a.status = ST_NO_DATA;
				end else begin
					a.read_byte = ring_mem[(ring_rd + r.offset) % DEPTH];
				end
			end
			ACT_DROP: begin
				if (r.count > u) begin
					a.status = ST_NO_DATA;
				end else begin
					ring_rd = (ring_rd + r.count) % DEPTH;
				end
			end
			ACT_ADVANCE: begin
				if (r.count > f) begin
					a.status = ST_NO_SPACE;
				end else begin
					ring_wr = (ring_wr + r.count) % DEPTH;
				end
			end
			ACT_CLEAR: begin
				ring_rd = 0;
				ring_wr = 0;
			end
			default: ;
		endcase
		u = ring_used();
		f = ring_free();
		a.used_count = u[CNT_W-1:0];
		a.free_count = f[CNT_W-1:0];
		return a;
	endfunction

	task automatic log_mismatch(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Compare results against the oldest outstanding answer, then model new requests
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			ring_rd = 0;
			ring_wr = 0;
			ring_answers.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[OUT_W-1:0]);
				res_total++;
				if (ring_answers.size() == 0) begin
					log_mismatch($sformatf("result %0d arrived with no request outstanding",
						res_total));
				end else begin
					want = ring_answers.pop_front();
					if (want.status != ST_DONE)
						refused_total++;
					if (got.read_byte !== want.read_byte || got.status !== want.status ||
					    got.used_count !== want.used_count ||
					    got.free_count !== want.free_count)
						log_mismatch($sformatf({"result %0d (exp/act): read_byte %0h/%0h ",
							"status %0d/%0d used %0d/%0d free %0d/%0d"}, res_total,
							want.read_byte, got.read_byte, want.status, got.status,
							want.used_count, got.used_count, want.free_count,
							got.free_count));
				end
			end
			if (s_tvalid && s_tready) begin
				req_total++;
				ring_answers.push_back(ring_apply(req_t'(s_tdata[IN_W-1:0])));
			end
			pending = ring_answers.size();
		end
	end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Top of the byte ring buffer bench: clock, reset, request and result stream
// drivers, stall watchdog and verdict. Depends on brb_pkg, byte_ring_buffer
// and brb_scoreboard.
`default_nettype none

module testbench;
	import brb_pkg::*;

	localparam int unsigned DEPTH        = DEPTH_DEF;
	localparam int unsigned GAP          = GAP_DEF;
	localparam int unsigned CAP          = DEPTH - GAP;
	localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;
	localparam int unsigned IDLE_PCT     = 19;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned HOLD_AT      = 100;
	localparam int unsigned HOLD_LEN     = 60;
	localparam int unsigned QUIET_FROM   = 250;
	localparam int unsigned QUIET_TO     = 330;
	localparam int unsigned DRAIN_CYCLES = 8;
	// slowest stretch without any handshake is the long receiver hold plus
	// a few random gaps; this allows many times that
	localparam int unsigned STALL_LIMIT  = 2000;

	// action codes with no defined effect
	localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned req_total;
	int unsigned res_total;
	int unsigned refused_total;

	bit          quiet;
	bit          hold_ask;
	int unsigned stall_cycles;

	// Stimulus-side view of the ring, used to size requests, count wraps and fills,
	// and to steer requests away from reading entries that were never pushed
	int unsigned plan_rd;
	int unsigned plan_wr;
	bit          plan_written [DEPTH];
	int unsigned wrap_hits;
	int unsigned full_hits;

	byte_ring_buffer #(.DEPTH(DEPTH), .GAP(GAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	brb_scoreboard #(.DEPTH(DEPTH), .GAP(GAP)) u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.req_total     (req_total),
		.res_total     (res_total),
		.refused_total (refused_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned plan_used();
		return (plan_wr + DEPTH - plan_rd) % DEPTH;
	endfunction

	function automatic int unsigned plan_step(int unsigned p, int unsigned n);
		if (p + n >= DEPTH)
			wrap_hits++;
		return (p + n) % DEPTH;
	endfunction

	// Track pointer movement and which entries hold pushed bytes
	function automatic void plan_commit(req_t r);
		int unsigned u;
		int unsigned f;
		u = plan_used();
		f = CAP - u;
		case (r.action)
			ACT_PUSH: begin
				if (f > 0) begin
					plan_written[plan_wr] = 1'b1;
					plan_wr = plan_step(plan_wr, 1);
				end
			end
			ACT_POP:     if (u > 0) plan_rd = plan_step(plan_rd, 1);
			ACT_DROP:    if (r.count <= u) plan_rd = plan_step(plan_rd, r.count);
			ACT_ADVANCE: if (r.count <= f) plan_wr = plan_step(plan_wr, r.count);
			ACT_CLEAR: begin
				plan_rd = 0;
				plan_wr = 0;
			end
			default: ;
		endcase
		if (plan_used() == CAP && u != CAP)
			full_hits++;
	endfunction

	function automatic req_t make_req(logic [ACT_W-1:0] a, logic [BYTE_W-1:0] d,
			logic [CNT_W-1:0] c, logic [CNT_W-1:0] o);
		req_t r;
		r.action    = a;
		r.data_byte = d;
		r.count     = c;
		r.offset    = o;
		return r;
	endfunction

	// Mostly sensible requests with random payload; some fully random noise
	function automatic req_t pick_request();
		req_t        r;
		int unsigned u;
		int unsigned f;
		int unsigned roll;
		int unsigned k;
		u = plan_used();
		f = CAP - u;
		r = req_t'(IN_W'($urandom));
		roll = $urandom_range(99);
		if (roll < 30) begin
			r.action = ACT_PUSH;
		end else if (roll < 48) begin
			r.action = ACT_POP;
		end else if (roll < 63) begin
			r.action = ACT_PEEK;
			if (u > 0 && $urandom_range(3) != 0)
				r.offset = CNT_W'($urandom_range(u - 1));
		end else if (roll < 73) begin
			r.action = ACT_DROP;
			k = $urandom_range(3);
			if (k < 2)
				r.count = CNT_W'($urandom_range((u < 6) ? u : 6));
			else if (k == 2)
				r.count = CNT_W'($urandom_range(u));
		end else if (roll < 87) begin
			r.action = ACT_ADVANCE;
			k = $urandom_range(3);
			if (k < 2)
				r.count = CNT_W'($urandom_range((f < 6) ? f : 6));
			else if (k == 2)
				r.count = CNT_W'($urandom_range(f));
		end else if (roll < 92) begin
			r.action = ACT_CLEAR;
		end else if (roll < 95) begin
			r.action = $urandom_range(1) ? ACT_SPARE7 : ACT_SPARE6;
		end else begin
			r.action = ACT_W'($urandom_range(7));
		end

		// never read an entry that no push has filled: skip over such a run
		// at the head instead of popping it, and move peeks out of range
		if (r.action == ACT_POP && u > 0 && !plan_written[plan_rd]) begin
			k = 0;
			while (k < u && !plan_written[(plan_rd + k) % DEPTH])
				k++;
			r.action = ACT_DROP;
			r.count  = CNT_W'(k);
		end
		if (r.action == ACT_PEEK && r.offset < u &&
		    !plan_written[(plan_rd + r.offset) % DEPTH])
			r.offset = CNT_W'($urandom_range(CNT_MAX, u));
		return r;
	endfunction

	// Offer one request after an optional random gap and wait for acceptance
	task automatic send_item(input req_t r);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		plan_commit(r);
		s_tdata  = IN_TDATA_W'(r);
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random back-pressure, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			m_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				stall_cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Main sequence
	initial begin
		int unsigned n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		quiet    = 1'b0;
		hold_ask = 1'b0;
		plan_rd  = 0;
		plan_wr  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty ring: refusals and zero counts
		send_item(make_req(ACT_POP, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_DROP, 8'h00, 10'd1, 10'd0));
		send_item(make_req(ACT_DROP, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_ADVANCE, 8'h00, 10'd0, 10'd0));
		// a few bytes, peek inside and just past the data
		send_item(make_req(ACT_PUSH, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_PUSH, 8'hFF, 10'd0, 10'd0));
		send_item(make_req(ACT_PUSH, 8'hA5, 10'd0, 10'd0));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd2));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd3));
		send_item(make_req(ACT_POP, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_SPARE6, 8'h5C, 10'd77, 10'd9));
		send_item(make_req(ACT_SPARE7, 8'hC3, 10'd1023, 10'd1023));
		// over-large drop and advance, then fill to capacity
		send_item(make_req(ACT_DROP, 8'h00, 10'd1023, 10'd0));
		send_item(make_req(ACT_ADVANCE, 8'h00, 10'd1015, 10'd0));
		send_item(make_req(ACT_ADVANCE, 8'h00, 10'd1014, 10'd0));
		// full ring
		send_item(make_req(ACT_PUSH, 8'h11, 10'd0, 10'd0));
		send_item(make_req(ACT_ADVANCE, 8'h00, 10'd1, 10'd0));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd1023));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd1));
		// empty it, then wrap both pointers past the end of the store
		send_item(make_req(ACT_DROP, 8'h00, 10'd1016, 10'd0));
		send_item(make_req(ACT_ADVANCE, 8'h00, 10'd10, 10'd0));
		send_item(make_req(ACT_PUSH, 8'h3C, 10'd0, 10'd0));
		send_item(make_req(ACT_PEEK, 8'h00, 10'd0, 10'd10));
		send_item(make_req(ACT_DROP, 8'h00, 10'd10, 10'd0));
		send_item(make_req(ACT_POP, 8'h00, 10'd0, 10'd0));
		send_item(make_req(ACT_CLEAR, 8'h00, 10'd0, 10'd0));

		// random traffic, with one long result hold and a stretch at full rate
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_ask = 1'b1;
			quiet = (n >= QUIET_FROM && n < QUIET_TO);
			send_item(pick_request());
		end
		quiet    = 1'b0;
		s_tvalid = 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d results, %0d of them refused.",
			req_total, res_total, refused_total);
		$display("Pointers wrapped %0d times; the ring reached capacity %0d times.",
			wrap_hits, full_hits);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
